// ===== rtl/indexed_list_insert_delete_defines.svh =====
// Assertion macros used by the checker file of the indexed list block.
// No dependencies; included by bare file name.
`ifndef INDEXED_LIST_INSERT_DELETE_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILID_ASSERT_IMP(lbl, ck, rn, ant, con, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ILID_ASSERT_NXT(lbl, ck, rn, ant, con, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (con)) else $error(msg);

`endif

// ===== rtl/ilid_pkg.sv =====
// Types and codes for the indexed list block.
// No dependencies; used by the controller, datapath, top level and checker.
package ilid_pkg;

    typedef enum logic [1:0] {
        OP_MODIFY = 2'd0,
        OP_SEARCH = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_MISS  = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic req_load;      // capture request beat
        logic apply;         // perform modify/insert/delete
        logic match_load;    // capture per-cell match vector
        logic scan_step;     // advance first-match scan
        logic out_load;      // load result register
        logic out_from_scan; // result comes from search scan
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_search;
        logic out_free;
        logic scan_hit;
        logic scan_zero;
    } stat_t;

endpackage

// ===== rtl/ilid_ctrl.sv =====
// Controller state machine for the indexed list block.
// Depends on ilid_pkg (cmd_t, stat_t).
module ilid_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ilid_pkg::stat_t stat,
    output ilid_pkg::cmd_t  cmd
);
    import ilid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_search)
                begin
                    cmd.match_load = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (stat.out_free)
                begin
                    cmd.apply    = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_hit || stat.scan_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.out_load      = 1'b1;
                        cmd.out_from_scan = 1'b1;
                        state_next        = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/ilid_dpath.sv =====
// Datapath of the indexed list: row of word cells with neighbour shift,
// per-cell compare, first-match scan and result register. Depends on ilid_pkg.
module ilid_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           in_func,
    input  logic [3:0]           in_position,
    input  logic signed [31:0]   in_value,
    input  ilid_pkg::cmd_t       cmd,
    output ilid_pkg::stat_t      stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [1:0]           out_status,
    output logic [3:0]           out_found_index,
    output logic [4:0]           out_length
);
    import ilid_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > 4) ? CW : 4;

    func_t              func_reg;
    logic [3:0]         pos_reg;
    logic signed [31:0] value_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] entries_reg [CAPACITY];
    logic [CAPACITY-1:0] match_reg, match_next;
    logic [IW-1:0]      idx_reg;
    logic               out_valid_reg;
    status_t            status_reg;
    logic [3:0]         found_reg;
    logic [4:0]         length_reg;
    logic               in_range;

    assign in_range = (CMPW'(pos_reg) < CMPW'(count_reg));

    always_comb
    begin
        count_next = count_reg;
        if (cmd.apply && in_range)
        begin
            if (func_reg == OP_INSERT && count_reg != CW'(CAPACITY))
            begin
                count_next = count_reg + CW'(1);
            end
            else if (func_reg == OP_DELETE)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic               at_pos, above_pos;
        logic signed [31:0] lower_w, upper_w, cell_next;

        assign at_pos    = (CMPW'(i) == CMPW'(pos_reg));
        assign above_pos = (CMPW'(i) > CMPW'(pos_reg));

        if (i == 0)
        begin : g_first
            assign lower_w = value_reg;
        end
        else
        begin : g_lower
            assign lower_w = entries_reg[i-1];
        end

        // top cell keeps its stale word on delete
        if (i == CAPACITY - 1)
        begin : g_last
            assign upper_w = entries_reg[i];
        end
        else
        begin : g_upper
            assign upper_w = entries_reg[i+1];
        end

        always_comb
        begin
            cell_next = entries_reg[i];
            if (cmd.apply && in_range)
            begin
                unique case (func_reg)
                    OP_MODIFY:
                    begin
                        if (at_pos)
                        begin
                            cell_next = value_reg;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (at_pos)
                        begin
                            cell_next = value_reg;
                        end
                        else if (above_pos)
                        begin
                            cell_next = lower_w;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (at_pos || above_pos)
                        begin
                            cell_next = upper_w;
                        end
                    end
                    OP_SEARCH:
                    begin
                        cell_next = entries_reg[i];
                    end
                endcase
            end
        end

        assign match_next[i] = (entries_reg[i] == value_reg) &&
                               (CMPW'(i) < CMPW'(count_reg));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                entries_reg[i] <= '1;
            end
            else
            begin
                entries_reg[i] <= cell_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CW'(CAPACITY);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            func_reg  <= func_t'(in_func);
            pos_reg   <= in_position;
            value_reg <= in_value;
        end
        if (cmd.match_load)
        begin
            match_reg <= match_next;
            idx_reg   <= '0;
        end
        else if (cmd.scan_step)
        begin
            match_reg <= match_reg >> 1;
            idx_reg   <= idx_reg + IW'(1);
        end
        if (cmd.out_load)
        begin
            if (cmd.out_from_scan)
            begin
                status_reg <= match_reg[0] ? ST_OK : ST_MISS;
                found_reg  <= match_reg[0] ? 4'(idx_reg) : 4'd0;
                length_reg <= 5'(count_reg);
            end
            else
            begin
                status_reg <= in_range ? ST_OK : ST_RANGE;
                found_reg  <= 4'd0;
                length_reg <= 5'(count_next);
            end
        end
    end

    assign stat.is_search = (func_reg == OP_SEARCH);
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.scan_hit  = match_reg[0];
    assign stat.scan_zero = (match_reg == '0);

    assign out_valid       = out_valid_reg;
    assign out_status      = status_reg;
    assign out_found_index = found_reg;
    assign out_length      = length_reg;

endmodule

// ===== rtl/indexed_list_insert_delete.sv =====
// Indexed array list of signed 32-bit words holding up to CAPACITY entries,
// all -1 and full length after reset. A request beat carries an operation
// (modify, search, insert, delete), a position and a value; each gives one
// result beat with status, first matching index and the new length.
// Modify, insert and delete go from the request register to the result
// register, insert and delete by a neighbour shift across the cell row,
// waiting while the output register is full. Search scans the registered
// compare vector one bit per cycle for the first match. The next request
// is taken once the result is in the output register, which holds it until
// the downstream side takes it. Depends on ilid_pkg, ilid_ctrl, ilid_dpath.
module indexed_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // position[3:0], value[35:4], zero pad
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // found_index[3:0], length[8:4], zero pad
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    import ilid_pkg::*;

    cmd_t       cmd;
    stat_t      stat;
    logic [3:0] found_index;
    logic [4:0] length;

    ilid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ilid_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_func         (s_axis_tuser),
        .in_position     (s_axis_tdata[3:0]),
        .in_value        (s_axis_tdata[35:4]),
        .cmd             (cmd),
        .stat            (stat),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_status      (m_axis_tuser),
        .out_found_index (found_index),
        .out_length      (length)
    );

    assign m_axis_tdata = {7'd0, length, found_index};

endmodule

// ===== rtl/ilid_checker.sv =====
// Port-level checker for the indexed list block, bound to the top level.
// Depends on ilid_pkg and indexed_list_insert_delete_defines.svh.
`include "indexed_list_insert_delete_defines.svh"

module ilid_checker #(
    parameter int CAPACITY = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import ilid_pkg::*;

    logic in_beat;
    assign in_beat = s_axis_tvalid && s_axis_tready;

    `ILID_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped before taken")
    // one request at a time: no second beat straight after an accepted one
    `ILID_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_beat, !s_axis_tready, "request taken while previous one in progress")
    `ILID_ASSERT_IMP(a_status_code, clk, rst_n, m_axis_tvalid, m_axis_tuser != 2'd3, "undefined status code")
    `ILID_ASSERT_IMP(a_index_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata[3:0] == 4'd0, "index non-zero on failed request")
    `ILID_ASSERT_IMP(a_length_cap, clk, rst_n, m_axis_tvalid && CAPACITY < 32, m_axis_tdata[8:4] <= 5'(CAPACITY), "length beyond capacity")

endmodule

bind indexed_list_insert_delete ilid_checker #(
    .CAPACITY (CAPACITY)
) u_ilid_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
